// ===== hw/rtl/pidci_pkg.sv =====
// Shared widths, register map, configuration type and converter constants.
package pidci_pkg;

  localparam int GAIN_FRAC_BITS = 8;
  localparam int DAC_SHIFT      = 5;
  localparam int DROP_BITS      = GAIN_FRAC_BITS + DAC_SHIFT;

  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 16;
  localparam int LIMIT_W  = 32;
  localparam int ERR_W    = SAMPLE_W + 1;
  localparam int DIFF_W   = ERR_W + 1;
  localparam int ACC_W    = LIMIT_W + 1;
  localparam int P_PROD_W = GAIN_W + ERR_W;
  localparam int I_PROD_W = GAIN_W + LIMIT_W;
  localparam int D_PROD_W = GAIN_W + DIFF_W;
  localparam int SUM_W    = I_PROD_W + 2;
  localparam int CODE_W   = 12;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 5;
  localparam int REG_IDX_W  = APB_ADDR_W - 2;

  localparam logic [CODE_W-1:0] DAC_MID = 12'd2048;
  localparam logic [CODE_W-1:0] DAC_TOP = 12'd4095;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PROP_GAIN  = 3'd0,
    REG_INTEG_GAIN = 3'd1,
    REG_DERIV_GAIN = 3'd2,
    REG_INTEG_MAX  = 3'd3,
    REG_INTEG_MIN  = 3'd4,
    REG_SETPOINT   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0]   prop_gain;
    logic signed [GAIN_W-1:0]   integ_gain;
    logic signed [GAIN_W-1:0]   deriv_gain;
    logic signed [LIMIT_W-1:0]  integ_max;
    logic signed [LIMIT_W-1:0]  integ_min;
    logic signed [SAMPLE_W-1:0] setpoint;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:  16'sd768,
    integ_gain: 16'sd256,
    deriv_gain: 16'sd256,
    integ_max:  32'sd1638400,
    integ_min:  -32'sd1638400,
    setpoint:   16'sd6554
  };

endpackage

// ===== hw/rtl/pidci_regs.sv =====
// Configuration register file behind the APB-style port.
module pidci_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pidci_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [pidci_pkg::APB_DATA_W-1:0] pwdata,
  output logic [pidci_pkg::APB_DATA_W-1:0] prdata,
  output pidci_pkg::cfg_t                  cfg
);
  import pidci_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign wr_en = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (wr_en) begin
      case (idx)
        REG_PROP_GAIN:  cfg_r.prop_gain  <= pwdata[GAIN_W-1:0];
        REG_INTEG_GAIN: cfg_r.integ_gain <= pwdata[GAIN_W-1:0];
        REG_DERIV_GAIN: cfg_r.deriv_gain <= pwdata[GAIN_W-1:0];
        REG_INTEG_MAX:  cfg_r.integ_max  <= pwdata[LIMIT_W-1:0];
        REG_INTEG_MIN:  cfg_r.integ_min  <= pwdata[LIMIT_W-1:0];
        REG_SETPOINT:   cfg_r.setpoint   <= pwdata[SAMPLE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read back sign-extended to the bus width
  always_comb begin
    case (idx)
      REG_PROP_GAIN:  prdata = APB_DATA_W'(cfg_r.prop_gain);
      REG_INTEG_GAIN: prdata = APB_DATA_W'(cfg_r.integ_gain);
      REG_DERIV_GAIN: prdata = APB_DATA_W'(cfg_r.deriv_gain);
      REG_INTEG_MAX:  prdata = APB_DATA_W'(cfg_r.integ_max);
      REG_INTEG_MIN:  prdata = APB_DATA_W'(cfg_r.integ_min);
      REG_SETPOINT:   prdata = APB_DATA_W'(cfg_r.setpoint);
      default:        prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

// ===== hw/rtl/pidci_core.sv =====
// Control datapath: error and integrator update, gain products, drive code.
module pidci_core (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  pidci_pkg::cfg_t                       cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [pidci_pkg::SAMPLE_W-1:0] in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [pidci_pkg::CODE_W-1:0]          out_code,
  output logic                                  out_sat
);
  import pidci_pkg::*;

  logic s1_v_r, s1_v_nxt;
  logic s2_v_r, s2_v_nxt;
  logic out_v_r, out_v_nxt;

  logic signed [LIMIT_W-1:0] integ_r;
  logic signed [ERR_W-1:0]   prev_err_r;
  logic signed [DIFF_W-1:0]  diff_r;

  logic signed [P_PROD_W-1:0] p_prod_r;
  logic signed [I_PROD_W-1:0] i_prod_r;
  logic signed [D_PROD_W-1:0] d_prod_r;

  logic [CODE_W-1:0] out_code_r;
  logic              out_sat_r;

  logic signed [ERR_W-1:0]  err_c;
  logic signed [DIFF_W-1:0] diff_c;
  logic signed [ACC_W-1:0]  acc_c, hi_c, clamp_c, max_c, min_c;
  logic signed [SUM_W-1:0]  sum_c, shifted_c, code_c;
  logic [CODE_W-1:0]        code_sat_c;
  logic                     sat_c;

  logic out_free, s2_free, s1_free;
  logic s1_move, s2_move, in_acc;

  // Pipeline flow: each stage loads when the one after it is empty or draining
  assign out_free = !out_v_r || out_ready;
  assign s2_move  = s2_v_r && out_free;
  assign s2_free  = !s2_v_r || out_free;
  assign s1_move  = s1_v_r && s2_free;
  assign s1_free  = !s1_v_r || s2_free;
  assign in_ready = s1_free;
  assign in_acc   = in_valid && s1_free;

  assign s1_v_nxt  = in_acc  ? 1'b1 : (s1_move ? 1'b0 : s1_v_r);
  assign s2_v_nxt  = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_v_r);
  assign out_v_nxt = s2_move ? 1'b1 : (out_ready ? 1'b0 : out_v_r);

  // Error and clamped integrator; upper limit first, lower limit wins
  assign err_c  = $signed({cfg.setpoint[SAMPLE_W-1], cfg.setpoint})
                - $signed({in_sample[SAMPLE_W-1], in_sample});
  assign diff_c = $signed({prev_err_r[ERR_W-1], prev_err_r})
                - $signed({err_c[ERR_W-1], err_c});
  assign acc_c   = ACC_W'(integ_r) + ACC_W'(err_c);
  assign max_c   = ACC_W'(cfg.integ_max);
  assign min_c   = ACC_W'(cfg.integ_min);
  assign hi_c    = (acc_c > max_c) ? max_c : acc_c;
  assign clamp_c = (hi_c < min_c) ? min_c : hi_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r     <= 1'b0;
      s2_v_r     <= 1'b0;
      out_v_r    <= 1'b0;
      integ_r    <= '0;
      prev_err_r <= '0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      out_v_r <= out_v_nxt;
      if (in_acc) begin
        integ_r    <= clamp_c[LIMIT_W-1:0];
        prev_err_r <= err_c;
      end
    end
  end

  // The state registers hold the values of the item in stage one until it moves on
  always_ff @(posedge clk) begin
    if (in_acc) begin
      diff_r <= diff_c;
    end
    if (s1_move) begin
      p_prod_r <= cfg.prop_gain * prev_err_r;
      i_prod_r <= cfg.integ_gain * integ_r;
      d_prod_r <= cfg.deriv_gain * diff_r;
    end
    if (s2_move) begin
      out_code_r <= code_sat_c;
      out_sat_r  <= sat_c;
    end
  end

  // Floor shift of the drive sum, offset to mid-scale, saturate
  assign sum_c     = SUM_W'(p_prod_r) + SUM_W'(i_prod_r) + SUM_W'(d_prod_r);
  assign shifted_c = sum_c >>> DROP_BITS;
  assign code_c    = shifted_c + $signed({{(SUM_W-CODE_W){1'b0}}, DAC_MID});

  always_comb begin
    if (code_c[SUM_W-1]) begin
      code_sat_c = '0;
      sat_c      = 1'b1;
    end else if (|code_c[SUM_W-2:CODE_W]) begin
      code_sat_c = DAC_TOP;
      sat_c      = 1'b1;
    end else begin
      code_sat_c = code_c[CODE_W-1:0];
      sat_c      = 1'b0;
    end
  end

  assign out_valid = out_v_r;
  assign out_code  = out_code_r;
  assign out_sat   = out_sat_r;

endmodule

// ===== hw/rtl/pid_controller_clamped_integrator.sv =====
// PID controller with clamped integrator: top level.
//
// Input stream: one converter sample per beat on in_tdata (signed counts).
// Each accepted sample gives exactly one result beat on the output stream:
// out_tdata carries the 12-bit DAC code (2048 is zero volts), out_tuser is
// set when that code was clamped to 0 or 4095.
// The gains, integrator limits and setpoint sit in registers on the APB-style
// cfg_ port (byte address 4 * register index); pready is always high. Write
// them only while no beat is in flight.
// The stages are error and integrator update, then the three gain products,
// then the sum, shift and saturation into the output register.
// Throughput is one sample per cycle while the receiver takes results; the
// integrator update is a loop through its own register.
// When the receiver stalls, the result holds and the three stages fill up,
// after which in_tready drops; it returns as soon as a result is taken.
// Synchronous reset restores the register defaults, clears the integrator
// and previous error, and empties the pipeline.
module pid_controller_clamped_integrator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [pidci_pkg::IN_DATA_W-1:0]    in_tdata,   // [15:0] sample
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [pidci_pkg::OUT_DATA_W-1:0]   out_tdata,  // [11:0] dac_code, [15:12] zero
  output logic                               out_tuser,  // [0] out_saturated
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [pidci_pkg::APB_ADDR_W-1:0]   cfg_paddr,
  input  logic [pidci_pkg::APB_DATA_W-1:0]   cfg_pwdata,
  output logic [pidci_pkg::APB_DATA_W-1:0]   cfg_prdata,
  output logic                               cfg_pready
);
  import pidci_pkg::*;

  cfg_t              cfg;
  logic [CODE_W-1:0] code;

  assign cfg_pready = 1'b1;

  pidci_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .cfg     (cfg)
  );

  pidci_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_sample ($signed(in_tdata[SAMPLE_W-1:0])),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_code  (code),
    .out_sat   (out_tuser)
  );

  assign out_tdata = {{(OUT_DATA_W-CODE_W){1'b0}}, code};

endmodule

// ===== hw/rtl/pidci_checker.sv =====
// Port-level checks for the PID controller, bound to the top level.
module pidci_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [pidci_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                             out_tuser
);
  import pidci_pkg::*;

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid straight after reset");

  // A stalled result beat holds its value
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed or dropped");

  // With the output register empty, nothing can block the input side
  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled while output stage empty");

  // The saturation flag only accompanies a code at either rail
  a_sat_at_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |->
      out_tdata[CODE_W-1:0] == '0 || out_tdata[CODE_W-1:0] == DAC_TOP)
    else $error("saturation flag on a code off the rails");

endmodule

bind pid_controller_clamped_integrator pidci_checker u_pidci_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/tb_pid_controller_clamped_integrator.sv =====
// Self-checking stream testbench for the clamped-integrator PID controller.
module tb_pid_controller_clamped_integrator;
  import pidci_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PIPE_DEPTH  = 3;
  localparam int IDLE_PCT    = 27;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic              sat;
  } dac_beat_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;    // [15:0] sample
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // [11:0] dac_code, [15:12] zero
  logic                  out_tuser;        // [0] out_saturated
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] cfg_paddr = '0;
  logic [APB_DATA_W-1:0] cfg_pwdata = '0;
  logic [APB_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Shadow of the block's registers and loop state
  cfg_t                    shadow_cfg = CFG_RESET;
  logic signed [LIMIT_W-1:0] integ_q = '0;
  logic signed [ERR_W-1:0]   prev_err_q = '0;

  dac_beat_t expected_dac[$];
  int        fail_count = 0;
  int        cycle_count = 0;
  int        hold_cycles = 0;
  bit        no_idle = 1'b0;

  pid_controller_clamped_integrator dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Advance the integrator and previous error; return the DAC beat they give
  function automatic dac_beat_t predict_dac(input logic signed [SAMPLE_W-1:0] meas);
    longint    err;
    longint    acc;
    longint    sum;
    longint    code;
    dac_beat_t beat;
    err = longint'(shadow_cfg.setpoint) - longint'(meas);
    acc = longint'(integ_q) + err;
    if (acc > longint'(shadow_cfg.integ_max)) acc = longint'(shadow_cfg.integ_max);
    if (acc < longint'(shadow_cfg.integ_min)) acc = longint'(shadow_cfg.integ_min);
    integ_q = acc[LIMIT_W-1:0];
    sum = longint'(shadow_cfg.prop_gain) * err
        + longint'(shadow_cfg.integ_gain) * longint'(integ_q)
        + longint'(shadow_cfg.deriv_gain) * (longint'(prev_err_q) - err);
    prev_err_q = err[ERR_W-1:0];
    sum = sum >>> DROP_BITS;
    code = sum + longint'(DAC_MID);
    beat.sat = 1'b0;
    if (code > longint'(DAC_TOP)) begin
      code = longint'(DAC_TOP);
      beat.sat = 1'b1;
    end else if (code < 0) begin
      code = 0;
      beat.sat = 1'b1;
    end
    beat.code = code[CODE_W-1:0];
    return beat;
  endfunction

  // Result monitor
  always @(posedge clk) begin
    dac_beat_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_dac.size() == 0) begin
        $error("unexpected result beat: dac_code %0d out_saturated %0b",
               out_tdata[CODE_W-1:0], out_tuser);
        fail_count++;
      end else begin
        want = expected_dac.pop_front();
        if (out_tdata[CODE_W-1:0] !== want.code) begin
          $error("dac_code: expected %0d, actual %0d", want.code, out_tdata[CODE_W-1:0]);
          fail_count++;
        end
        if (out_tuser !== want.sat) begin
          $error("out_saturated: expected %0b, actual %0b", want.sat, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Receiver: random back-pressure, plus a counted hold-off on request
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_tready = 1'b0;
      hold_cycles--;
    end else begin
      out_tready = no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  task automatic send_meas(input logic [SAMPLE_W-1:0] meas);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = meas;
    do @(posedge clk); while (!in_tready);
    expected_dac.push_back(predict_dac(meas));
  endtask

  // Drop valid and wait until every expected beat has come back
  task automatic drain;
    @(negedge clk);
    in_tvalid = 1'b0;
    while (expected_dac.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = {idx, 2'b00};
    cfg_pwdata  = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (reg_idx_t'(idx))
      REG_PROP_GAIN:  shadow_cfg.prop_gain  = val[GAIN_W-1:0];
      REG_INTEG_GAIN: shadow_cfg.integ_gain = val[GAIN_W-1:0];
      REG_DERIV_GAIN: shadow_cfg.deriv_gain = val[GAIN_W-1:0];
      REG_INTEG_MAX:  shadow_cfg.integ_max  = val;
      REG_INTEG_MIN:  shadow_cfg.integ_min  = val;
      REG_SETPOINT:   shadow_cfg.setpoint   = val[SAMPLE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic load_cfg(input cfg_t c);
    cfg_write(REG_PROP_GAIN,  32'(c.prop_gain));
    cfg_write(REG_INTEG_GAIN, 32'(c.integ_gain));
    cfg_write(REG_DERIV_GAIN, 32'(c.deriv_gain));
    cfg_write(REG_INTEG_MAX,  c.integ_max);
    cfg_write(REG_INTEG_MIN,  c.integ_min);
    cfg_write(REG_SETPOINT,   32'(c.setpoint));
  endtask

  task automatic test_reset_values;
    send_meas(16'sd6554);
    send_meas(16'sd0);
    send_meas(16'sh7fff);
    send_meas(16'sh8000);
    drain();
  endtask

  // Largest error magnitudes in both directions
  task automatic test_input_extremes;
    cfg_write(REG_SETPOINT, 32'hffff_8000);
    send_meas(16'sh7fff);
    drain();
    cfg_write(REG_SETPOINT, 32'h0000_7fff);
    send_meas(16'sh8000);
    send_meas(16'sh8000);
    drain();
  endtask

  task automatic test_gain_extremes;
    cfg_write(REG_PROP_GAIN,  32'hffff_8000);
    cfg_write(REG_INTEG_GAIN, 32'h0000_7fff);
    cfg_write(REG_DERIV_GAIN, 32'hffff_8000);
    send_meas(16'sh1234);
    send_meas(16'shc000);
    drain();
    cfg_write(REG_PROP_GAIN,  32'h0);
    cfg_write(REG_INTEG_GAIN, 32'h0);
    cfg_write(REG_DERIV_GAIN, 32'h0);
    send_meas(16'sh8000);
    drain();
  endtask

  // Lower clamp applied last wins when the limits cross
  task automatic test_inverted_clamp;
    cfg_t c;
    c = CFG_RESET;
    c.integ_max = -32'sd100;
    c.integ_min = 32'sd100;
    load_cfg(c);
    send_meas(16'sd6554);
    send_meas(16'sh7fff);
    send_meas(16'sh8000);
    drain();
  endtask

  // Park the integrator next to either end of the 32-bit range, then push past it
  task automatic test_integrator_wrap;
    cfg_write(REG_INTEG_MAX, 32'h7fff_ffff);
    cfg_write(REG_INTEG_MIN, 32'h7fff_ffd0);
    send_meas(16'sh8000);
    send_meas(16'sh8000);
    drain();
    cfg_write(REG_INTEG_MIN, 32'h8000_0000);
    cfg_write(REG_INTEG_MAX, 32'h8000_0030);
    send_meas(16'sh7fff);
    send_meas(16'sh7fff);
    drain();
  endtask

  // Tiny negative drive must floor one code below mid-scale
  task automatic test_floor_rounding;
    cfg_t c;
    c = CFG_RESET;
    c.prop_gain  = 16'sd1;
    c.integ_gain = 16'sd0;
    c.deriv_gain = 16'sd0;
    c.setpoint   = 16'sd0;
    load_cfg(c);
    send_meas(16'sd1);
    send_meas(-16'sd1);
    send_meas(16'sd8192);
    drain();
  endtask

  task automatic test_drive_saturation;
    cfg_t c;
    c = CFG_RESET;
    c.setpoint = 16'sd0;
    load_cfg(c);
    send_meas(16'sh8000);
    send_meas(16'sh7fff);
    drain();
  endtask

  // Writes beyond the register map must leave everything unchanged
  task automatic test_unmapped_register;
    load_cfg(CFG_RESET);
    cfg_write(3'd6, 32'hffff_ffff);
    cfg_write(3'd7, 32'h5a5a_a5a5);
    send_meas(16'sd100);
    send_meas(16'sd9000);
    send_meas(-16'sd3000);
    drain();
  endtask

  // Stall the receiver long enough for the pipeline to fill and block the input
  task automatic test_receiver_hold_off;
    no_idle = 1'b1;
    send_meas(16'($urandom));
    hold_cycles = 300;
    repeat (60) send_meas(16'($urandom));
    no_idle = 1'b0;
    drain();
  endtask

  task automatic test_random_phases;
    cfg_t c;
    int   lim;
    int   s;
    for (int phase = 0; phase < 12; phase++) begin
      c = CFG_RESET;
      if (phase == 1) begin
        c.prop_gain  = 16'sh7fff;
        c.integ_gain = 16'sh7fff;
        c.deriv_gain = 16'sh7fff;
        c.integ_max  = 32'sh7fff_ffff;
        c.integ_min  = 32'sh8000_0000;
        c.setpoint   = 16'sh7fff;
      end else if (phase == 2) begin
        c.prop_gain  = 16'sh8000;
        c.integ_gain = 16'sh8000;
        c.deriv_gain = 16'sh8000;
        c.integ_max  = 32'sh8000_0000;
        c.integ_min  = 32'sh7fff_ffff;
        c.setpoint   = 16'sh8000;
      end else if (phase != 0) begin
        c.prop_gain  = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048) - 1024);
        c.integ_gain = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(512) - 256);
        c.deriv_gain = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(2048) - 1024);
        lim = $urandom_range(200000);
        case ($urandom_range(3))
          0: begin
            c.integ_max = $urandom;
            c.integ_min = $urandom;
          end
          1: begin
            c.integ_max = -lim;
            c.integ_min = lim;
          end
          default: begin
            c.integ_max = lim;
            c.integ_min = -32'sd1 * $urandom_range(200000);
          end
        endcase
        c.setpoint = 16'($urandom);
      end
      load_cfg(c);
      no_idle = (phase == 0);
      repeat (165) begin
        if ($urandom_range(9) < 6) begin
          s = int'(c.setpoint) + $urandom_range(4000) - 2000;
          if (s > 32767) s = 32767;
          if (s < -32768) s = -32768;
          send_meas(16'(s));
        end else begin
          send_meas(16'($urandom));
        end
      end
      no_idle = 1'b0;
      drain();
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_reset_values();
    test_input_extremes();
    test_gain_extremes();
    test_inverted_clamp();
    test_integrator_wrap();
    test_floor_rounding();
    test_drive_saturation();
    test_unmapped_register();
    test_receiver_hold_off();
    test_random_phases();
    drain();
    if (fail_count == 0 && expected_dac.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
